// ----- rtl/srct_pkg.sv -----
// Package for the sparse row-to-column transpose block.
// Holds the sizing constants, item layouts and controller state type; no dependencies.
package srct_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;
    localparam int MAX_NNZ  = 4096;

    localparam int ROW_W   = 10;
    localparam int COL_W   = 10;
    localparam int VAL_W   = 64;
    localparam int DIM_W   = 11;                     // num_rows / num_cols registers
    localparam int CNT_W   = 13;                     // counts, pointers, positions
    localparam int NNZ_AW  = $clog2(MAX_NNZ);        // entry store address
    localparam int COL_AW  = $clog2(MAX_COLS);       // column count address
    localparam int PTR_AW  = $clog2(MAX_COLS + 1);   // column start address

    localparam int S_DATA_W = 152;                   // row, col, re, im padded to bytes
    localparam int M_DATA_W = 144;                   // index, re, im padded to bytes

    localparam logic       OP_LOAD   = 1'b0;
    localparam logic       OP_PULL   = 1'b1;
    localparam logic       KIND_PTR  = 1'b0;
    localparam logic       KIND_ENT  = 1'b1;
    localparam logic       REG_ROWS  = 1'b0;
    localparam logic       REG_COLS  = 1'b1;

    typedef enum logic [3:0] {
        ST_CLR,      // sweep column counts to zero
        ST_IDLE,     // loading phase, take loads and the first pull
        ST_LD_WR,    // write back incremented column count
        ST_PFX_RD,   // read one column count
        ST_PFX_WR,   // write start pointer and cursor
        ST_SC_RD,    // read one loaded entry
        ST_SC_COL,   // check column, read its cursor
        ST_SC_WR,    // place entry, bump cursor
        ST_EM_ISS,   // issue reads for the first pull
        ST_EM_IDLE,  // emitting phase, wait for a pull
        ST_EM_OUT    // capture result into output register
    } t_state;

endpackage

// ----- rtl/sparse_row_to_column_transpose.sv -----
// Top level of the sparse row-to-column transpose (CSR to CSC) block.
// Uses srct_pkg for constants and the controller state type.
//
// Loads (tuser op 0) store one nonzero each through a read-modify-write of
// the column count memory. The first pull builds the column start pointers
// and scatters the entries before its result appears. Each later pull reads
// the start or sorted-entry memory into the output register. After the last
// result a clearing pass zeroes all 1024 column counts; the same pass runs
// after reset. No item is taken during it, configuration writes are.
// Configuration writes while results are pending are ignored.
module sparse_row_to_column_transpose (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // row[9:0], col[19:10], value_re[83:20], value_im[147:84], zero[151:148]
    input  logic [srct_pkg::S_DATA_W-1:0] i_s_tdata,
    // op[0]
    input  logic                          i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // index[12:0], out_re[76:13], out_im[140:77], zero[143:141]
    output logic [srct_pkg::M_DATA_W-1:0] o_m_tdata,
    // kind[0], dropped[1]
    output logic [1:0]                    o_m_tuser,
    output logic                          o_m_tlast,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [srct_pkg::DIM_W-1:0]    i_cfg_data
);
    import srct_pkg::*;

    localparam int LD_W = ROW_W + COL_W + 2 * VAL_W;
    localparam int SO_W = ROW_W + 2 * VAL_W;

    // memories
    logic [LD_W-1:0]  loaded_mem [MAX_NNZ];
    logic [SO_W-1:0]  sorted_mem [MAX_NNZ];
    logic [CNT_W-1:0] cnt_mem    [MAX_COLS];
    logic [CNT_W-1:0] start_mem  [MAX_COLS + 1];

    logic [LD_W-1:0]   ld_q;
    logic [SO_W-1:0]   so_q;
    logic [CNT_W-1:0]  cnt_q;
    logic [CNT_W-1:0]  start_q;

    logic              ld_we, so_we, cnt_we, cnt_re, start_we, ld_re, so_re, start_re;
    logic [NNZ_AW-1:0] ld_wa, ld_ra, so_wa, so_ra;
    logic [LD_W-1:0]   ld_wd;
    logic [SO_W-1:0]   so_wd;
    logic [COL_AW-1:0] cnt_wa, cnt_ra;
    logic [CNT_W-1:0]  cnt_wd, start_wd;
    logic [PTR_AW-1:0] start_wa, start_ra;

    always_ff @(posedge i_clk) begin
        if (ld_we) loaded_mem[ld_wa] <= ld_wd;
        if (ld_re) ld_q <= loaded_mem[ld_ra];
    end

    always_ff @(posedge i_clk) begin
        if (so_we) sorted_mem[so_wa] <= so_wd;
        if (so_re) so_q <= sorted_mem[so_ra];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
        if (cnt_re) cnt_q <= cnt_mem[cnt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (start_we) start_mem[start_wa] <= start_wd;
        if (start_re) start_q <= start_mem[start_ra];
    end

    // control registers
    t_state             r_state, n_state;
    logic [DIM_W-1:0]   r_num_rows, r_num_cols;
    logic [CNT_W-1:0]   r_entry_count, n_entry_count;
    logic [CNT_W-1:0]   r_pos, n_pos;          // emit position
    logic [CNT_W-1:0]   r_idx, n_idx;          // sweep, column or entry index
    logic [CNT_W-1:0]   r_acc, n_acc;          // prefix sum
    logic [CNT_W-1:0]   r_total, n_total;      // results in this matrix
    logic [COL_W-1:0]   r_col, n_col;
    logic               r_dropped, n_dropped;
    logic               r_out_valid, n_out_valid;
    logic [CNT_W-1:0]   r_out_index, n_out_index;
    logic [VAL_W-1:0]   r_out_re, n_out_re, r_out_im, n_out_im;
    logic               r_out_kind, n_out_kind, r_out_last, n_out_last, r_out_drop, n_out_drop;

    logic [DIM_W-1:0]  nc, nr;
    logic              s_acc, is_ptr, is_last, emitting;
    logic [ROW_W-1:0]  in_row;
    logic [COL_W-1:0]  in_col;
    logic [CNT_W-1:0]  ent_k;

    assign nc       = (r_num_cols > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : r_num_cols;
    assign nr       = (r_num_rows > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : r_num_rows;
    assign in_row   = i_s_tdata[ROW_W-1:0];
    assign in_col   = i_s_tdata[ROW_W+COL_W-1:ROW_W];
    assign is_ptr   = r_pos <= CNT_W'(nc);
    assign ent_k    = r_pos - CNT_W'(nc) - CNT_W'(1);
    assign is_last  = ({1'b0, r_pos} + 14'd1) >= {1'b0, r_total};
    assign emitting = !(r_state == ST_CLR || r_state == ST_IDLE || r_state == ST_LD_WR);

    assign o_s_tready  = !r_out_valid && (r_state == ST_IDLE || r_state == ST_EM_IDLE);
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= DIM_W'(1024);
            r_num_cols <= DIM_W'(1024);
        end else if (i_cfg_valid && !emitting) begin
            unique case (i_cfg_index)
                REG_ROWS: r_num_rows <= i_cfg_data;
                REG_COLS: r_num_cols <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    always_comb begin
        n_state       = r_state;
        n_entry_count = r_entry_count;
        n_pos         = r_pos;
        n_idx         = r_idx;
        n_acc         = r_acc;
        n_total       = r_total;
        n_col         = r_col;
        n_dropped     = r_dropped;
        n_out_valid   = r_out_valid && !i_m_tready;
        n_out_index   = r_out_index;
        n_out_re      = r_out_re;
        n_out_im      = r_out_im;
        n_out_kind    = r_out_kind;
        n_out_last    = r_out_last;
        n_out_drop    = r_out_drop;

        ld_we = 1'b0;  ld_wa = r_entry_count[NNZ_AW-1:0];  ld_wd = i_s_tdata[LD_W-1:0];
        ld_re = 1'b0;  ld_ra = r_idx[NNZ_AW-1:0];
        so_we = 1'b0;  so_wa = cnt_q[NNZ_AW-1:0];
        so_wd = {ld_q[LD_W-1:ROW_W+COL_W], ld_q[ROW_W-1:0]};
        so_re = 1'b0;  so_ra = ent_k[NNZ_AW-1:0];
        cnt_we = 1'b0; cnt_wa = r_idx[COL_AW-1:0]; cnt_wd = '0;
        cnt_re = 1'b0; cnt_ra = r_idx[COL_AW-1:0];
        start_we = 1'b0; start_wa = '0; start_wd = '0;
        start_re = 1'b0; start_ra = r_pos[PTR_AW-1:0];

        unique case (r_state)
            ST_CLR: begin
                cnt_we = 1'b1;
                n_idx  = r_idx + CNT_W'(1);
                if (r_idx == CNT_W'(MAX_COLS - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_acc && i_s_tuser == OP_LOAD) begin
                    if ({1'b0, in_row} >= nr || {1'b0, in_col} >= nc ||
                        r_entry_count >= CNT_W'(MAX_NNZ)) begin
                        n_dropped = 1'b1;
                    end else begin
                        ld_we   = 1'b1;
                        cnt_re  = 1'b1;
                        cnt_ra  = in_col[COL_AW-1:0];
                        n_col   = in_col;
                        n_state = ST_LD_WR;
                    end
                end else if (s_acc) begin
                    start_we = 1'b1;           // first pointer is zero
                    n_idx    = '0;
                    n_acc    = '0;
                    n_pos    = '0;
                    n_state  = ST_PFX_RD;
                end
            end
            ST_LD_WR: begin
                cnt_we        = 1'b1;
                cnt_wa        = r_col[COL_AW-1:0];
                cnt_wd        = cnt_q + CNT_W'(1);
                n_entry_count = r_entry_count + CNT_W'(1);
                n_state       = ST_IDLE;
            end
            ST_PFX_RD: begin
                if (r_idx == CNT_W'(nc)) begin
                    n_total = CNT_W'(nc) + CNT_W'(1) + r_acc;
                    n_idx   = '0;
                    n_state = ST_SC_RD;
                end else begin
                    cnt_re  = 1'b1;
                    n_state = ST_PFX_WR;
                end
            end
            ST_PFX_WR: begin
                start_we = 1'b1;
                start_wa = PTR_AW'(r_idx + CNT_W'(1));
                start_wd = r_acc + cnt_q;
                cnt_we   = 1'b1;
                cnt_wd   = r_acc;               // count becomes write cursor
                n_acc    = r_acc + cnt_q;
                n_idx    = r_idx + CNT_W'(1);
                n_state  = ST_PFX_RD;
            end
            ST_SC_RD: begin
                if (r_idx == r_entry_count) begin
                    n_state = ST_EM_ISS;
                end else begin
                    ld_re   = 1'b1;
                    n_state = ST_SC_COL;
                end
            end
            ST_SC_COL: begin
                if ({1'b0, ld_q[ROW_W+COL_W-1:ROW_W]} >= nc) begin
                    n_dropped = 1'b1;           // column narrowed since loading
                    n_idx     = r_idx + CNT_W'(1);
                    n_state   = ST_SC_RD;
                end else begin
                    cnt_re  = 1'b1;
                    cnt_ra  = ld_q[ROW_W+COL_AW-1:ROW_W];
                    n_state = ST_SC_WR;
                end
            end
            ST_SC_WR: begin
                so_we   = 1'b1;
                cnt_we  = 1'b1;
                cnt_wa  = ld_q[ROW_W+COL_AW-1:ROW_W];
                cnt_wd  = cnt_q + CNT_W'(1);
                n_idx   = r_idx + CNT_W'(1);
                n_state = ST_SC_RD;
            end
            ST_EM_ISS: begin
                start_re = is_ptr;
                so_re    = !is_ptr;
                n_state  = ST_EM_OUT;
            end
            ST_EM_IDLE: begin
                // loads while emitting are taken and ignored
                if (s_acc && i_s_tuser == OP_PULL) begin
                    start_re = is_ptr;
                    so_re    = !is_ptr;
                    n_state  = ST_EM_OUT;
                end
            end
            ST_EM_OUT: begin
                n_out_valid = 1'b1;
                n_out_kind  = is_ptr ? KIND_PTR : KIND_ENT;
                n_out_index = is_ptr ? start_q : CNT_W'(so_q[ROW_W-1:0]);
                n_out_re    = is_ptr ? '0 : so_q[ROW_W+VAL_W-1:ROW_W];
                n_out_im    = is_ptr ? '0 : so_q[SO_W-1:ROW_W+VAL_W];
                n_out_last  = is_last;
                n_out_drop  = r_dropped;
                if (is_last) begin
                    n_entry_count = '0;
                    n_dropped     = 1'b0;
                    n_pos         = '0;
                    n_idx         = '0;
                    n_state       = ST_CLR;
                end else begin
                    n_pos   = r_pos + CNT_W'(1);
                    n_state = ST_EM_IDLE;
                end
            end
            default: n_state = ST_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLR;
            r_entry_count <= '0;
            r_pos         <= '0;
            r_idx         <= '0;
            r_dropped     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_entry_count <= n_entry_count;
            r_pos         <= n_pos;
            r_idx         <= n_idx;
            r_dropped     <= n_dropped;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc       <= n_acc;
        r_total     <= n_total;
        r_col       <= n_col;
        r_out_index <= n_out_index;
        r_out_re    <= n_out_re;
        r_out_im    <= n_out_im;
        r_out_kind  <= n_out_kind;
        r_out_last  <= n_out_last;
        r_out_drop  <= n_out_drop;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_im, r_out_re, r_out_index};
    assign o_m_tuser  = {r_out_drop, r_out_kind};
    assign o_m_tlast  = r_out_last;

    a_ready_only_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !r_out_valid)
        else $error("input taken while a result is held");

    a_entry_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_entry_count <= CNT_W'(MAX_NNZ))
        else $error("entry count beyond capacity");

    a_count_writeback_follows_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LD_WR) |-> $past(i_s_tvalid && o_s_tready && i_s_tuser == OP_LOAD))
        else $error("count write-back without an accepted load");

endmodule
